[sv/ofdr_pkg.sv]
// Shared types and codes for the oldest-first deflection router.
// No dependencies; imported by the router top level.
package ofdr_pkg;

	// request kind codes
	localparam logic [1:0] KIND_NET    = 2'd0;
	localparam logic [1:0] KIND_INJECT = 2'd1;
	localparam logic [1:0] KIND_ROUTE  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam int PORT_W  = 3;
	localparam int TAG_W   = 16;
	localparam int TIME_W  = 32;
	localparam int DELTA_W = 8;
	localparam int DPACK_W = 3 * DELTA_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCAN,
		ST_EMIT
	} state_t;

endpackage

[sv/ofdr_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies; used for the injection queue.
module ofdr_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[sv/oldest_first_deflection_router_unit.sv]
// Oldest-first bufferless deflection router: flit latch, injection queue,
// iterative oldest-first selection and port allocation. Uses ofdr_pkg, ofdr_ram.
//
//  channel | signals                                           | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid/in_ready, kind, flit_tag, birth_time,    | request in
//          | delta_x, delta_y, delta_z                         |
//  out     | out_valid/out_ready, has_flit, out_tag, out_port, | result out
//          | deflected, inject_stop, last                      |
//
// Network and injection requests are taken while idle. A route request is
// accepted, the queue head joins the latched flits, then for each of the n
// latched flits the shared age comparator visits all n slots and the result
// waits for out_ready. No request is taken while results are out.
// Reset clears counts, pointers and masks; flit and queue storage is not cleared.
module oldest_first_deflection_router_unit #(
	parameter int NET_PORTS    = 4,
	parameter int INJECT_DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        kind,
	input  logic [ofdr_pkg::TAG_W-1:0]        flit_tag,
	input  logic [ofdr_pkg::TIME_W-1:0]       birth_time,
	input  logic signed [ofdr_pkg::DELTA_W-1:0] delta_x,
	input  logic signed [ofdr_pkg::DELTA_W-1:0] delta_y,
	input  logic signed [ofdr_pkg::DELTA_W-1:0] delta_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              has_flit,
	output logic [ofdr_pkg::TAG_W-1:0]        out_tag,
	output logic [ofdr_pkg::PORT_W-1:0]       out_port,
	output logic                              deflected,
	output logic                              inject_stop,
	output logic                              last
);
	import ofdr_pkg::*;

	localparam int CW    = $clog2(NET_PORTS + 1);
	localparam int IW    = $clog2(NET_PORTS);
	localparam int PW    = (INJECT_DEPTH > 1) ? $clog2(INJECT_DEPTH) : 1;
	localparam int QW    = $clog2(INJECT_DEPTH + 1);
	localparam int INFO_W = TAG_W + TIME_W;
	localparam int QE_W  = INFO_W + DPACK_W;

	state_t state_q, state_d;

	// latched flits of this router cycle
	logic [TAG_W-1:0]   slot_tag_q  [NET_PORTS];
	logic [TIME_W-1:0]  slot_time_q [NET_PORTS];
	logic [DPACK_W-1:0] slot_del_q  [NET_PORTS];
	logic [CW-1:0]      cnt_q;

	// injection queue pointers
	logic [PW-1:0] head_q, tail_q;
	logic [QW-1:0] qcnt_q;
	logic          q_wr;
	logic [QE_W-1:0] q_rdata;

	// selection and allocation state
	logic [IW-1:0]      idx_q, bsel_q;
	logic [TIME_W-1:0]  btime_q;
	logic [TAG_W-1:0]   btag_q;
	logic [DPACK_W-1:0] bdel_q;
	logic               bhave_q;
	logic [NET_PORTS-1:0] served_q;
	logic [NET_PORTS:0]   taken_q;
	logic [CW-1:0]      emit_k_q;
	logic               join_q;
	logic               stop_q;

	logic in_acc, out_acc;
	logic scan_last, cand;
	logic [IW-1:0]      sel_idx;
	logic [TAG_W-1:0]   sel_tag;
	logic [DPACK_W-1:0] sel_del;
	logic [NET_PORTS:0] prod;
	logic [PORT_W-1:0]  alloc_port;
	logic               alloc_found, alloc_defl;
	logic signed [DELTA_W-1:0] sdx, sdy, sdz;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(INJECT_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// injection queue storage
	assign q_wr = in_acc && (kind == KIND_INJECT) && (qcnt_q != QW'(INJECT_DEPTH));

	ofdr_ram #(
		.WIDTH(QE_W),
		.DEPTH(INJECT_DEPTH),
		.AW   (PW)
	) u_inj_ram (
		.clk    (clk),
		.wr_en  (q_wr),
		.wr_addr(tail_q),
		.wr_data({flit_tag, birth_time, delta_z, delta_y, delta_x}),
		.rd_addr(head_q),
		.rd_data(q_rdata)
	);

	// age compare: unserved and strictly older wins, ties stay with lower slot
	assign cand = !served_q[idx_q] && (!bhave_q || (slot_time_q[idx_q] < btime_q));
	assign scan_last = (CW'(idx_q) == cnt_q - 1'b1);
	assign sel_idx = cand ? idx_q : bsel_q;
	assign sel_tag = cand ? slot_tag_q[idx_q] : btag_q;
	assign sel_del = cand ? slot_del_q[idx_q] : bdel_q;

	// productive ports of the selected flit
	always_comb begin
		sdx = sel_del[DELTA_W-1:0];
		sdy = sel_del[2*DELTA_W-1:DELTA_W];
		sdz = sel_del[3*DELTA_W-1:2*DELTA_W];
		prod = '0;
		for (int i = 0; i < NET_PORTS; i++) begin
			case (i)
				0: prod[i] = sdx > 8'sd1;
				1: prod[i] = sdx < -8'sd1;
				2: prod[i] = sdy > 8'sd1;
				3: prod[i] = sdy < -8'sd1;
				4: prod[i] = sdz > 8'sd1;
				default: prod[i] = sdz < -8'sd1;
			endcase
		end
		prod[NET_PORTS] = (sdx == 8'sd1 || sdx == -8'sd1) &&
				(sdy == 8'sd1 || sdy == -8'sd1) &&
				(sdz == 8'sd1 || sdz == -8'sd1);
	end

	// first free productive port, else first free network port
	always_comb begin
		alloc_found = 1'b0;
		alloc_defl  = 1'b0;
		alloc_port  = PORT_W'(NET_PORTS);
		for (int i = 0; i <= NET_PORTS; i++) begin
			if (!alloc_found && !taken_q[i] && prod[i]) begin
				alloc_found = 1'b1;
				alloc_port  = PORT_W'(i);
			end
		end
		if (!alloc_found) begin
			alloc_defl = 1'b1;
			for (int i = 0; i < NET_PORTS; i++) begin
				if (!alloc_found && !taken_q[i]) begin
					alloc_found = 1'b1;
					alloc_port  = PORT_W'(i);
				end
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc && kind == KIND_ROUTE) state_d = ST_LOAD;
			ST_LOAD: begin
				if (cnt_q == '0 && !join_q) state_d = ST_EMIT;
				else state_d = ST_SCAN;
			end
			ST_SCAN: if (scan_last) state_d = ST_EMIT;
			ST_EMIT: if (out_acc) state_d = last ? ST_IDLE : ST_SCAN;
			default: state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready  = 1'b1;
			ST_EMIT: out_valid = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			qcnt_q   <= '0;
			idx_q    <= '0;
			bhave_q  <= 1'b0;
			served_q <= '0;
			taken_q  <= '0;
			emit_k_q <= '0;
			join_q   <= 1'b0;
			stop_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && kind == KIND_NET && cnt_q != CW'(NET_PORTS)) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (q_wr) begin
						tail_q <= ptr_inc(tail_q);
						qcnt_q <= qcnt_q + 1'b1;
					end
					if (in_acc && kind == KIND_ROUTE) begin
						join_q <= (cnt_q != CW'(NET_PORTS)) && (qcnt_q != '0);
					end
				end
				ST_LOAD: begin
					if (join_q) begin
						cnt_q  <= cnt_q + 1'b1;
						head_q <= ptr_inc(head_q);
						qcnt_q <= qcnt_q - 1'b1;
						stop_q <= (qcnt_q != QW'(1));
					end else begin
						stop_q <= (qcnt_q != '0);
					end
					idx_q    <= '0;
					bhave_q  <= 1'b0;
					emit_k_q <= '0;
				end
				ST_SCAN: begin
					if (cand) bhave_q <= 1'b1;
					if (scan_last) begin
						idx_q <= '0;
						served_q[sel_idx] <= 1'b1;
						if (alloc_found) taken_q[alloc_port] <= 1'b1;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_acc) begin
						emit_k_q <= emit_k_q + 1'b1;
						bhave_q  <= 1'b0;
						if (last) begin
							cnt_q    <= '0;
							served_q <= '0;
							taken_q  <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers: flit slots, best candidate, result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc && kind == KIND_NET && cnt_q != CW'(NET_PORTS)) begin
			slot_tag_q[cnt_q[IW-1:0]]  <= flit_tag;
			slot_time_q[cnt_q[IW-1:0]] <= birth_time;
			slot_del_q[cnt_q[IW-1:0]]  <= {delta_z, delta_y, delta_x};
		end
		if (state_q == ST_LOAD) begin
			if (join_q) begin
				slot_tag_q[cnt_q[IW-1:0]]  <= q_rdata[QE_W-1:QE_W-TAG_W];
				slot_time_q[cnt_q[IW-1:0]] <= q_rdata[DPACK_W+TIME_W-1:DPACK_W];
				slot_del_q[cnt_q[IW-1:0]]  <= q_rdata[DPACK_W-1:0];
			end
			// empty router cycle result
			has_flit    <= 1'b0;
			out_tag     <= '0;
			out_port    <= '0;
			deflected   <= 1'b0;
			inject_stop <= join_q ? (qcnt_q != QW'(1)) : (qcnt_q != '0);
			last        <= 1'b1;
		end
		if (state_q == ST_SCAN) begin
			if (cand) begin
				bsel_q  <= idx_q;
				btime_q <= slot_time_q[idx_q];
				btag_q  <= slot_tag_q[idx_q];
				bdel_q  <= slot_del_q[idx_q];
			end
			if (scan_last) begin
				has_flit    <= 1'b1;
				out_tag     <= sel_tag;
				out_port    <= alloc_port;
				deflected   <= alloc_defl;
				inject_stop <= stop_q;
				last        <= (emit_k_q + 1'b1 == cnt_q);
			end
		end
	end

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("request and result sides open together");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(NET_PORTS))
		else $error("flit count beyond network ports");
	a_qcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= QW'(INJECT_DEPTH))
		else $error("injection count beyond depth");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last) |=> in_ready)
		else $error("not idle after last result");
	a_taken_once: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && has_flit && !last) |=> $countones(taken_q) == $countones($past(taken_q)))
		else $error("port mask changed outside allocation");

endmodule
